[rtl/core/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Types, constants and the saturation helper shared by the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DW = 16;          // width of one operand or result part
  localparam int XW = 3 * DW + 2;  // wide signed width ahead of saturation
  localparam int QDEPTH = 4;       // front-to-back queue depth

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  req_type;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 saturated;
    logic                 div_by_zero;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     dz;
  } q_entry_t;

  typedef struct packed {
    logic signed [DW-1:0] v;
    logic                 sat;
  } clip_t;

  function automatic clip_t sat_clip(input logic signed [XW-1:0] v);
    clip_t                c;
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = ~hi;
    c.sat = 1'b0;
    if (v > hi) begin
      c.v   = hi[DW-1:0];
      c.sat = 1'b1;
    end else if (v < lo) begin
      c.v   = lo[DW-1:0];
      c.sat = 1'b1;
    end else begin
      c.v = v[DW-1:0];
    end
    return c;
  endfunction

endpackage

[rtl/core/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front
// Accepts command beats and tags divides by a zero divisor.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
  input  logic     start,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     busy,
  output logic     push,
  output q_entry_t entry
);

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    entry.item = in_item;
    entry.dz   = (in_item.req_type == OP_DIV) &&
                 (in_item.b_re == '0) && (in_item.b_im == '0);
  end

endmodule

[rtl/core/cau_queue.sv]
// ----------------------------------------------------------------------------
// cau_queue
// Small register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module cau_queue import cau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wr_entry,
  input  logic     pop,
  output logic     valid,
  output logic     full,
  output q_entry_t rd_entry
);

  localparam int PW = $clog2(QDEPTH);

  q_entry_t        mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     cnt_r;

  assign valid    = (cnt_r != '0);
  assign full     = (cnt_r == (PW+1)'(QDEPTH));
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_entry;
  end

endmodule

[rtl/core/cau_div.sv]
// ----------------------------------------------------------------------------
// cau_div
// Radix-2 restoring divider, two lanes sharing one divisor (quotient re/im).
// ----------------------------------------------------------------------------
module cau_div import cau_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [2*DW:0]   num_re,
  input  logic signed [2*DW:0]   num_im,
  input  logic [2*DW-1:0]        den,
  output logic                   busy,
  output logic                   done,
  output out_item_t              res
);

  localparam int PW = 2 * DW;
  localparam int NB = PW + 1 + FRAC_BITS;
  localparam int CW = $clog2(NB);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [PW-1:0]   den_r;
  logic [NB-1:0]   d_r   [2];
  logic [PW-1:0]   rem_r [2];
  logic            neg_r [2];
  logic [NB-1:0]   d_nxt   [2];
  logic [PW-1:0]   rem_nxt [2];
  logic [PW:0]     mag     [2];
  logic            last;

  assign last = (cnt_r == CW'(NB - 1));
  assign busy = busy_r || done_r;
  assign done = done_r;

  always_comb begin
    logic [PW:0] rs;
    logic        ge;
    mag[0] = num_re[PW] ? (PW+1)'(0) - num_re : num_re;
    mag[1] = num_im[PW] ? (PW+1)'(0) - num_im : num_im;
    for (int l = 0; l < 2; l++) begin
      rs         = {rem_r[l], d_r[l][NB-1]};
      ge         = (rs >= {1'b0, den_r});
      rem_nxt[l] = ge ? PW'(rs - {1'b0, den_r}) : rs[PW-1:0];
      d_nxt[l]   = {d_r[l][NB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      for (int l = 0; l < 2; l++) begin
        d_r[l]   <= NB'(mag[l]) << FRAC_BITS;
        rem_r[l] <= '0;
      end
      neg_r[0] <= num_re[PW];
      neg_r[1] <= num_im[PW];
    end else if (busy_r) begin
      for (int l = 0; l < 2; l++) begin
        d_r[l]   <= d_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
    end
  end

  always_comb begin
    logic signed [XW-1:0] q [2];
    clip_t                c [2];
    for (int l = 0; l < 2; l++) begin
      q[l] = neg_r[l] ? XW'(0) - XW'(d_r[l]) : XW'(d_r[l]);
      c[l] = sat_clip(q[l]);
    end
    res.res_re      = c[0].v;
    res.res_im      = c[1].v;
    res.saturated   = c[0].sat || c[1].sat;
    res.div_by_zero = 1'b0;
  end

endmodule

[rtl/core/cau_back.sv]
// ----------------------------------------------------------------------------
// cau_back
// Execution side: product stage, combine/saturate stage, divider, result reg.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  q_entry,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int PW = 2 * DW;
  localparam logic [PW:0] RND = (PW+1)'((64'd1 << FRAC_BITS) - 64'd1);

  logic                 s1_valid_r;
  op_t                  s1_op_r;
  logic                 s1_dz_r;
  logic signed [DW:0]   s1_sre_r;
  logic signed [DW:0]   s1_sim_r;
  logic signed [PW-1:0] s1_p_r [6];

  logic                 s1_go;
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  out_item_t            div_res;
  logic signed [PW:0]   nre;
  logic signed [PW:0]   nim;
  logic [PW-1:0]        den;

  logic                 out_valid_r;
  out_item_t            out_item_r;
  logic                 out_valid_nxt;
  out_item_t            out_item_nxt;

  in_item_t             hd;

  assign hd        = q_entry.item;
  assign s1_go     = s1_valid_r && !div_busy;
  assign pop       = q_valid && (!s1_valid_r || s1_go);
  assign div_start = s1_go && (s1_op_r == OP_DIV) && !s1_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pop) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op_r   <= hd.req_type;
      s1_dz_r   <= q_entry.dz;
      s1_sre_r  <= (hd.req_type == OP_SUB) ? (DW+1)'(hd.a_re) - (DW+1)'(hd.b_re)
                                           : (DW+1)'(hd.a_re) + (DW+1)'(hd.b_re);
      s1_sim_r  <= (hd.req_type == OP_SUB) ? (DW+1)'(hd.a_im) - (DW+1)'(hd.b_im)
                                           : (DW+1)'(hd.a_im) + (DW+1)'(hd.b_im);
      s1_p_r[0] <= PW'(hd.a_re) * PW'(hd.b_re);
      s1_p_r[1] <= PW'(hd.a_im) * PW'(hd.b_im);
      s1_p_r[2] <= PW'(hd.a_re) * PW'(hd.b_im);
      s1_p_r[3] <= PW'(hd.a_im) * PW'(hd.b_re);
      s1_p_r[4] <= PW'(hd.b_re) * PW'(hd.b_re);
      s1_p_r[5] <= PW'(hd.b_im) * PW'(hd.b_im);
    end
  end

  assign nre = (PW+1)'(s1_p_r[0]) + (PW+1)'(s1_p_r[1]);
  assign nim = (PW+1)'(s1_p_r[3]) - (PW+1)'(s1_p_r[2]);
  assign den = $unsigned(s1_p_r[4]) + $unsigned(s1_p_r[5]);

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_re (nre),
    .num_im (nim),
    .den    (den),
    .busy   (div_busy),
    .done   (div_done),
    .res    (div_res)
  );

  always_comb begin
    logic signed [PW:0]   mre;
    logic signed [PW:0]   mim;
    logic signed [PW:0]   tre;
    logic signed [PW:0]   tim;
    logic signed [XW-1:0] xre;
    logic signed [XW-1:0] xim;
    clip_t                cre;
    clip_t                cim;
    mre = (PW+1)'(s1_p_r[0]) - (PW+1)'(s1_p_r[1]);
    mim = (PW+1)'(s1_p_r[2]) + (PW+1)'(s1_p_r[3]);
    tre = $signed(mre + (mre[PW] ? RND : '0)) >>> FRAC_BITS;
    tim = $signed(mim + (mim[PW] ? RND : '0)) >>> FRAC_BITS;
    xre = XW'(s1_sre_r);
    xim = XW'(s1_sim_r);
    cre = '0;
    cim = '0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    if (div_done) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = div_res;
    end else if (s1_go) begin
      case (s1_op_r)
        OP_ADD, OP_SUB: begin
          out_valid_nxt = 1'b1;
        end
        OP_MUL: begin
          out_valid_nxt = 1'b1;
          xre           = XW'(tre);
          xim           = XW'(tim);
        end
        OP_DIV: begin
          out_valid_nxt = s1_dz_r;
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
      cre = sat_clip(xre);
      cim = sat_clip(xim);
      if (s1_op_r == OP_DIV) begin
        out_item_nxt.div_by_zero = 1'b1;
      end else begin
        out_item_nxt.res_re    = cre.v;
        out_item_nxt.res_im    = cim.v;
        out_item_nxt.saturated = cre.sat || cim.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_done && s1_go))
    else $error("divider and stage 1 retire in the same cycle");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.div_by_zero |->
      out_item_r.res_re == '0 && out_item_r.res_im == '0 && !out_item_r.saturated)
    else $error("divide by zero result not cleared");

  a_busy_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && div_busy |=> s1_valid_r)
    else $error("stage 1 item dropped while divider busy");
`endif

endmodule

[rtl/core/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add/sub/mul/div on signed fixed point with saturation.
//
//   channel   handshake               payload
//   command   start / busy            in_item  (in_item_t)
//   result    out_valid (1-cycle)     out_item (out_item_t)
//
// Add, subtract, multiply pass the command queue, the product registers and the
// result register, one beat per cycle sustained while no divide is in progress.
// Divide runs in the bit-serial divider (Q8.8 at the default FRAC_BITS); items
// behind it queue up and wait, results stay in order. busy rises when the
// 4-entry command queue is full. Reset is synchronous and clears all control
// state; receiver cannot stall.
module complex_arith_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic     q_full;
  logic     push;
  q_entry_t wr_entry;
  logic     pop;
  logic     q_valid;
  q_entry_t rd_entry;

  cau_front u_front (
    .start   (start),
    .in_item (in_item),
    .q_full  (q_full),
    .busy    (busy),
    .push    (push),
    .entry   (wr_entry)
  );

  cau_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .valid    (q_valid),
    .full     (q_full),
    .rd_entry (rd_entry)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (rd_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
